[design/assert_macros.svh]
// assertion macros used by the btlv design file btlv_core
// no dependencies; included by btlv_core, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define BTLV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("btlv same-cycle check failed");
// next-cycle implication, disabled while reset is asserted
`define BTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("btlv next-cycle check failed");
`else
`define BTLV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/btlv_pkg.sv]
// types and constants for the ber tlv stream parser
// no dependencies; used by btlv_core and ber_tlv_stream_parser
`default_nettype none

package btlv_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int WORD_W    = 32;
    localparam int LCNT_W    = 7;
    localparam int FORM_BIT  = 7;

    localparam logic [LEN_W-1:0] LEN_SAT   = 16'hFFFF;
    localparam logic [LEN_W-1:0] LEN_LIMIT = 16'h00FF;

    // parser phase; the code doubles as the role of the byte taken in that phase
    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN1 = 2'd1,
        PH_LENX = 2'd2,
        PH_VAL  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]        role;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] tag;
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] word;
        logic              done;
        logic              err;
    } t_result;

endpackage

`default_nettype wire

[design/ber_tlv_stream_parser.sv]
// top level of the ber tlv stream parser: input register, decode core, result register
// depends on btlv_pkg and btlv_core
//
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_byte_in, i_restart
// out       output     o_out_valid / i_out_ready  o_byte_role .. o_length_error
//
// one byte per cycle sustained while the output side is ready
// each byte passes input register -> decode and state update -> result register
// the parser state updates when a byte moves from the input register to the result register
// a stalled result register holds the byte in the input register; no new byte is taken meanwhile
// reset is synchronous, active low, and leaves the parser expecting a tag
`default_nettype none

module ber_tlv_stream_parser #(
    parameter int MAX_LENGTH_BYTES = 2,
    parameter int VALUE_WORD_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_restart,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_byte_role,
    output logic [7:0]       o_byte_out,
    output logic [7:0]       o_tag_value,
    output logic [15:0]      o_value_length,
    output logic [31:0]      o_value_word,
    output logic             o_record_done,
    output logic             o_length_error
);

    logic                         r_in_valid;
    logic [btlv_pkg::BYTE_W-1:0]  r_in_byte;
    logic                         r_in_restart;
    logic                         r_out_valid;
    btlv_pkg::t_result            r_out;
    btlv_pkg::t_result            step_result;
    logic                         advance;
    logic                         step;

    // handshake control
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte    <= i_byte_in;
            r_in_restart <= i_restart;
        end
    end

    btlv_core #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
        .VALUE_WORD_BITS  (VALUE_WORD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .o_result  (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    // output fields
    assign o_out_valid    = r_out_valid;
    assign o_byte_role    = r_out.role;
    assign o_byte_out     = r_out.data;
    assign o_tag_value    = r_out.tag;
    assign o_value_length = r_out.len;
    assign o_value_word   = r_out.word;
    assign o_record_done  = r_out.done;
    assign o_length_error = r_out.err;

endmodule

`default_nettype wire

[design/btlv_core.sv]
// tlv decode state machine: parser state registers and per-byte result logic
// depends on btlv_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module btlv_core #(
    parameter int MAX_LENGTH_BYTES = 2,
    parameter int VALUE_WORD_BITS  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [btlv_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                          i_restart,
    output btlv_pkg::t_result                  o_result
);

    localparam int VW = VALUE_WORD_BITS;

    btlv_pkg::t_phase                r_phase, n_phase;
    logic [btlv_pkg::BYTE_W-1:0]     r_tag, n_tag;
    logic [btlv_pkg::LCNT_W-1:0]     r_len_left, n_len_left;
    logic [btlv_pkg::LEN_W-1:0]      r_len_acc, n_len_acc;
    logic [btlv_pkg::LEN_W-1:0]      r_val_left, n_val_left;
    logic [VW-1:0]                   r_val_acc, n_val_acc;
    logic                            r_err, n_err;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= btlv_pkg::PH_TAG;
            r_tag      <= '0;
            r_len_left <= '0;
            r_len_acc  <= '0;
            r_val_left <= '0;
            r_val_acc  <= '0;
            r_err      <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tag      <= n_tag;
            r_len_left <= n_len_left;
            r_len_acc  <= n_len_acc;
            r_val_left <= n_val_left;
            r_val_acc  <= n_val_acc;
            r_err      <= n_err;
        end
    end

    // next state and result for the byte at the input
    always_comb begin
        logic [btlv_pkg::LCNT_W-1:0] low;
        logic [btlv_pkg::LEN_W-1:0]  len_out;
        logic [VW+7:0]               shifted;
        btlv_pkg::t_phase            role;
        logic                        done;

        low        = i_byte[btlv_pkg::LCNT_W-1:0];
        len_out    = '0;
        shifted    = {r_val_acc, i_byte};
        role       = r_phase;
        done       = 1'b0;
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_len_left = r_len_left;
        n_len_acc  = r_len_acc;
        n_val_left = r_val_left;
        n_val_acc  = r_val_acc;
        n_err      = r_err;

        if (i_restart || r_phase == btlv_pkg::PH_TAG) begin
            // new record: tag byte
            role       = btlv_pkg::PH_TAG;
            n_tag      = i_byte;
            n_len_left = '0;
            n_len_acc  = '0;
            n_val_left = '0;
            n_val_acc  = '0;
            n_err      = 1'b0;
            n_phase    = btlv_pkg::PH_LEN1;
        end else begin
            unique case (r_phase)
                btlv_pkg::PH_LEN1: begin
                    n_len_acc = '0;
                    if (!i_byte[btlv_pkg::FORM_BIT]) begin
                        // short form
                        n_len_acc  = btlv_pkg::LEN_W'(low);
                        len_out    = btlv_pkg::LEN_W'(low);
                        n_val_left = btlv_pkg::LEN_W'(low);
                        n_val_acc  = '0;
                        done       = (low == '0);
                        n_phase    = done ? btlv_pkg::PH_TAG : btlv_pkg::PH_VAL;
                    end else if (low == '0) begin
                        // indefinite form
                        n_err   = 1'b1;
                        done    = 1'b1;
                        n_phase = btlv_pkg::PH_TAG;
                    end else begin
                        // long form, count of length bytes
                        if (low > btlv_pkg::LCNT_W'(MAX_LENGTH_BYTES)) begin
                            n_err = 1'b1;
                        end
                        n_len_left = low;
                        n_phase    = btlv_pkg::PH_LENX;
                    end
                end
                btlv_pkg::PH_LENX: begin
                    if (!r_err) begin
                        if (r_len_acc > btlv_pkg::LEN_LIMIT) begin
                            n_len_acc = btlv_pkg::LEN_SAT;
                        end else begin
                            n_len_acc = {r_len_acc[btlv_pkg::BYTE_W-1:0], i_byte};
                        end
                    end
                    if (r_len_left != '0) begin
                        n_len_left = r_len_left - 1'b1;
                    end
                    len_out = n_len_acc;
                    if (n_len_left == '0) begin
                        if (r_err) begin
                            done    = 1'b1;
                            n_phase = btlv_pkg::PH_TAG;
                        end else begin
                            n_val_left = n_len_acc;
                            n_val_acc  = '0;
                            done       = (n_len_acc == '0);
                            n_phase    = done ? btlv_pkg::PH_TAG : btlv_pkg::PH_VAL;
                        end
                    end
                end
                btlv_pkg::PH_VAL: begin
                    n_val_acc = shifted[VW-1:0];
                    if (r_val_left != '0) begin
                        n_val_left = r_val_left - 1'b1;
                    end
                    if (n_val_left == '0) begin
                        done    = 1'b1;
                        n_phase = btlv_pkg::PH_TAG;
                    end
                    len_out = r_len_acc;
                end
                default: begin
                    n_phase = btlv_pkg::PH_TAG;
                end
            endcase
        end

        o_result.role = role;
        o_result.data = i_byte;
        o_result.tag  = n_tag;
        o_result.len  = len_out;
        o_result.word = (role == btlv_pkg::PH_VAL) ?
                        btlv_pkg::WORD_W'(n_val_acc) : '0;
        o_result.done = done;
        o_result.err  = n_err;
    end

    // a tag byte always moves the parser to the first length byte
    `BTLV_ASSERT_NEXT(a_tag_to_len1, i_clk, i_rst_n, i_step && (i_restart || r_phase == btlv_pkg::PH_TAG), r_phase == btlv_pkg::PH_LEN1)
    // the last byte of a record leaves the parser waiting for a tag
    `BTLV_ASSERT_NEXT(a_done_to_tag, i_clk, i_rst_n, i_step && o_result.done, r_phase == btlv_pkg::PH_TAG)
    // value phase always has bytes still owed
    `BTLV_ASSERT_SAME(a_val_nonzero, i_clk, i_rst_n, r_phase == btlv_pkg::PH_VAL, r_val_left != '0)
    // length phase always has length bytes still owed
    `BTLV_ASSERT_SAME(a_lenx_nonzero, i_clk, i_rst_n, r_phase == btlv_pkg::PH_LENX, r_len_left != '0)

endmodule

`default_nettype wire
